[src/serial_bank_mapper_assert.svh]
// ----------------------------------------------------------------------------
// Serial bank mapper assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_BANK_MAPPER_ASSERT_SVH
`define SERIAL_BANK_MAPPER_ASSERT_SVH

`ifndef SYNTH
`define SBM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sbm assertion failed");
`define SBM_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("sbm forbidden condition seen");
`else
`define SBM_ASSERT(label, prop)
`define SBM_ASSERT_NEVER(label, expr)
`endif

`endif

[src/sbm_pkg.sv]
// ----------------------------------------------------------------------------
// Serial bank mapper package
// Shared types, constants and the program ROM address translation.
// ----------------------------------------------------------------------------
`default_nettype none

package sbm_pkg;

  localparam int unsigned BankBits  = 14;   // 16 KiB banks
  localparam int unsigned MaxBanks  = 64;
  localparam int unsigned BankIdxW  = 6;    // log2(MaxBanks)
  localparam int unsigned RomAddrW  = BankIdxW + BankBits;
  localparam int unsigned CountW    = 7;
  localparam int unsigned RegW      = 5;

  localparam logic [CountW-1:0] CountReset  = 7'd2;
  localparam logic [RegW-1:0]   ShiftMarker = 5'h10;
  localparam logic [RegW-1:0]   ModeBits    = 5'h0C;

  localparam logic [1:0] AddrPrgBankCount = 2'd0;

  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_CHR_A   = 2'd1,
    SEL_CHR_B   = 2'd2,
    SEL_PRG     = 2'd3
  } sbm_sel_e;

  typedef struct packed {
    logic [RegW-1:0] control;
    logic [RegW-1:0] chr_a;
    logic [RegW-1:0] chr_b;
    logic [RegW-1:0] prg;
  } sbm_regs_t;

  typedef struct packed {
    logic                ok;
    logic [RomAddrW-1:0] rom;
  } sbm_xlate_t;

  // Fixed-last-bank translation: lower half switchable, upper half last bank.
  function automatic sbm_xlate_t sbm_translate(logic [CountW-1:0] count,
                                               logic [RegW-1:0]   prg,
                                               logic [15:0]       addr);
    sbm_xlate_t        res;
    logic              hi;
    logic [CountW-1:0] bank;
    res.ok = (count != '0) && (count <= CountW'(MaxBanks)) && !addr[15];
    // single bank: upper half folds onto the lower half
    hi   = addr[BankBits] && (count != CountW'(1));
    bank = hi ? (count - CountW'(1)) : {{(CountW-4){1'b0}}, prg[3:0]};
    if (bank >= count) begin
      res.ok = 1'b0;
    end
    res.rom = res.ok ? {bank[BankIdxW-1:0], addr[BankBits-1:0]} : '0;
    return res;
  endfunction

endpackage

`default_nettype wire

[src/sbm_serial_load.sv]
// ----------------------------------------------------------------------------
// Serial bank mapper loader
// Five-write serial shift register and the control and bank registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_serial_load import sbm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_en_i,
  input  wire logic [1:0] sel_i,
  input  wire logic [7:0] data_i,
  output sbm_regs_t       regs_o,      // register values after this beat
  output logic            ctrl_load_o
);

  logic [RegW-1:0] shift_q, shift_d, shifted;
  sbm_regs_t       regs_q, regs_d;
  sbm_sel_e        sel;

  assign sel     = sbm_sel_e'(sel_i);
  assign shifted = {data_i[0], shift_q[RegW-1:1]};

  always_comb begin
    shift_d     = shift_q;
    regs_d      = regs_q;
    ctrl_load_o = 1'b0;
    if (wr_en_i) begin
      if (data_i[7:4] != 4'h0) begin
        shift_d        = ShiftMarker;
        regs_d.control = regs_q.control | ModeBits;
      end else if (shift_q[0]) begin
        shift_d = ShiftMarker;
        unique case (sel)
          SEL_CONTROL: begin
            regs_d.control = shifted;
            ctrl_load_o    = 1'b1;
          end
          SEL_CHR_A: regs_d.chr_a = shifted;
          SEL_CHR_B: regs_d.chr_b = shifted;
          SEL_PRG:   regs_d.prg   = shifted;
          default:   regs_d.prg   = shifted;
        endcase
      end else begin
        shift_d = shifted;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q        <= ShiftMarker;
      regs_q.control <= ModeBits;
      regs_q.chr_a   <= '0;
      regs_q.chr_b   <= '0;
      regs_q.prg     <= '0;
    end else begin
      shift_q <= shift_d;
      regs_q  <= regs_d;
    end
  end

  assign regs_o = regs_d;

endmodule

`default_nettype wire

[src/serial_bank_mapper.sv]
// ----------------------------------------------------------------------------
// Serial bank mapper
// Cartridge program bank mapper with serial register loading.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             tuser op, tdata addr+data
//   m_axis    out  tvalid/tready             tuser status, tdata results
//   apb       in   psel/penable/pwrite       prg_bank_count at 0x0
//
// One beat per cycle sustained while m_axis_tready keeps up; each result appears in the
// cycle after its beat is accepted, held in the result register. A new beat enters while
// the previous result is being taken. Register state updates when the input beat is
// accepted. Reset sets all mapper registers to fixed values; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_bank_mapper import sbm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // address[15:0], write_data[23:16]
  input  wire logic [0:0]  s_axis_tuser,   // operation[0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // rom_address[19:0], mirroring_mode[21:20],
                                           // mirroring_changed[22], chr_bank_first[27:23],
                                           // chr_bank_second[32:28], zero[39:33]
  output logic [0:0]       m_axis_tuser,   // status[0]
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic              in_beat, is_write, wr_en, ctrl_load;
  logic [15:0]       addr;
  logic [7:0]        wdata;
  sbm_regs_t         regs;
  sbm_xlate_t        xl;
  logic [CountW-1:0] count_q;

  logic                m_valid_q;
  logic                status_q;
  logic [RomAddrW-1:0] rom_q;
  logic [1:0]          mirror_q;
  logic                changed_q;
  logic [RegW-1:0]     chr_a_q, chr_b_q;

  // config
  assign pready = 1'b1;
  assign prdata = (paddr == AddrPrgBankCount) ? {{(32-CountW){1'b0}}, count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (psel && penable && pwrite && paddr == AddrPrgBankCount) begin
      count_q <= pwdata[CountW-1:0];
    end
  end

  // input
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign addr          = s_axis_tdata[15:0];
  assign wdata         = s_axis_tdata[23:16];
  assign is_write      = s_axis_tuser[0];
  assign wr_en         = in_beat && is_write && !addr[15];

  sbm_serial_load u_load (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .sel_i       (addr[14:13]),
    .data_i      (wdata),
    .regs_o      (regs),
    .ctrl_load_o (ctrl_load)
  );

  assign xl = sbm_translate(count_q, regs.prg, addr);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      m_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      status_q  <= is_write ? addr[15] : !xl.ok;
      rom_q     <= is_write ? '0 : xl.rom;
      mirror_q  <= regs.control[1:0];
      changed_q <= ctrl_load;
      chr_a_q   <= regs.chr_a;
      chr_b_q   <= regs.chr_b;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {7'b0, chr_b_q, chr_a_q, changed_q, mirror_q, rom_q};

`include "serial_bank_mapper_assert.svh"

  `SBM_ASSERT(a_changed_ok, (m_axis_tvalid && m_axis_tdata[22]) |-> !m_axis_tuser[0])
  `SBM_ASSERT(a_rom_ok, (m_axis_tvalid && m_axis_tdata[19:0] != '0) |-> !m_axis_tuser[0])
  `SBM_ASSERT_NEVER(a_stall_blocks, m_axis_tvalid && !m_axis_tready && s_axis_tready)

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Serial bank mapper testbench
// Drives bus reads and writes into the mapper stream, predicts each result
// beat with a behavioral model of the serial loader and fixed-last-bank
// translation, and compares every result field but the zero padding. The bank count
// register is rewritten between phases, including zero and out-of-range counts. Both
// stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import sbm_pkg::*;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusOob = 1'b1;

  localparam int unsigned BankBytes   = 1 << BankBits;
  localparam int unsigned WindowBytes = 32'h8000;
  localparam int unsigned CycleLimit  = 200000;

  typedef struct packed {
    logic        status;
    logic [19:0] rom;
    logic [1:0]  mirror;
    logic        changed;
    logic [4:0]  chr_first;
    logic [4:0]  chr_second;
  } map_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // address[15:0], write_data[23:16]
  logic [0:0]  s_axis_tuser = '0;   // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // rom_address[19:0], mirroring_mode[21:20],
                                    // mirroring_changed[22], chr_bank_first[27:23],
                                    // chr_bank_second[32:28]
  logic [0:0]  m_axis_tuser;        // status[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  serial_bank_mapper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // mapper model state
  logic [CountW-1:0] bank_count  = CountReset;
  logic [RegW-1:0]   shift_q     = ShiftMarker;
  logic [RegW-1:0]   control_q   = ModeBits;
  logic [RegW-1:0]   chr_a_q     = '0;
  logic [RegW-1:0]   chr_b_q     = '0;
  logic [RegW-1:0]   prg_q       = '0;

  map_result_t mapped_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int          burst_left = 0;
  logic        ready_level = 1'b0;
  int          ready_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic map_result_t map_access(op_e op, logic [15:0] addr, logic [7:0] data);
    map_result_t     res;
    int unsigned     a;
    int unsigned     bank;
    int unsigned     count;
    logic            full;
    logic [RegW-1:0] value;
    res = '0;
    res.status = StatusOk;
    a = addr;
    count = bank_count;
    if (op == OP_READ) begin
      if (count == 0 || count > MaxBanks || a >= WindowBytes) begin
        res.status = StatusOob;
      end else begin
        if (a >= count * BankBytes) a -= BankBytes;
        bank = (a < BankBytes) ? int'(prg_q[3:0]) : count - 1;
        if (bank >= count) res.status = StatusOob;
        else res.rom = 20'((a % BankBytes) + bank * BankBytes);
      end
    end else if (a >= WindowBytes) begin
      res.status = StatusOob;
    end else if (data[7:4] != 4'h0) begin
      shift_q = ShiftMarker;
      control_q = control_q | ModeBits;
    end else begin
      full = shift_q[0];
      shift_q = {data[0], shift_q[4:1]};
      if (full) begin
        value = shift_q;
        shift_q = ShiftMarker;
        case (sbm_sel_e'(addr[14:13]))
          SEL_CONTROL: begin
            control_q = value;
            res.changed = 1'b1;
          end
          SEL_CHR_A: chr_a_q = value;
          SEL_CHR_B: chr_b_q = value;
          default:   prg_q = value;
        endcase
      end
    end
    res.mirror = control_q[1:0];
    res.chr_first = chr_a_q;
    res.chr_second = chr_b_q;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    map_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mapped_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual tdata 0x%0h tuser %0d",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = mapped_q.pop_front();
        check_field("status", want.status, m_axis_tuser[0]);
        check_field("rom_address", want.rom, m_axis_tdata[19:0]);
        check_field("mirroring_mode", want.mirror, m_axis_tdata[21:20]);
        check_field("mirroring_changed", want.changed, m_axis_tdata[22]);
        check_field("chr_bank_first", want.chr_first, m_axis_tdata[27:23]);
        check_field("chr_bank_second", want.chr_second, m_axis_tdata[32:28]);
      end
    end
  end

  // receiver stall pattern: short toggles with occasional long ready runs
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_level = !ready_level;
      if (ready_level)
        ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      else
        ready_left = $urandom_range(1, 5);
    end
    ready_left--;
    m_axis_tready <= ready_level;
  end

  task automatic issue_access(op_e op, logic [15:0] addr, logic [7:0] data);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {data, addr};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    mapped_q.push_back(map_access(op, addr, data));
    burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (mapped_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_bank_count(logic [CountW-1:0] count);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrPrgBankCount;
    pwdata <= 32'(count);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    bank_count = count;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_register(sbm_sel_e sel, logic [RegW-1:0] value);
    for (int i = 0; i < RegW; i++) begin
      issue_access(OP_WRITE, {1'b0, sel, 13'($urandom)}, {4'h0, 3'($urandom), value[i]});
    end
  endtask

  task automatic test_reset_reads();
    issue_access(OP_READ, 16'h0000, 8'h00);
    issue_access(OP_READ, 16'h7FFF, 8'hFF);
    issue_access(OP_READ, 16'h8000, 8'h00);
    issue_access(OP_WRITE, 16'hFFFF, 8'h01);
  endtask

  task automatic test_serial_loads();
    issue_access(OP_WRITE, 16'h0001, 8'h01);
    issue_access(OP_WRITE, 16'h0002, 8'h00);
    issue_access(OP_WRITE, 16'h1234, 8'h80);   // restart mid sequence
    load_register(SEL_CONTROL, 5'h03);
    load_register(SEL_PRG, 5'h1F);
    issue_access(OP_READ, 16'h0000, 8'h00);    // bank 15 beyond count
    issue_access(OP_READ, 16'h4000, 8'h00);
    load_register(SEL_CHR_A, 5'h15);
    issue_access(OP_WRITE, 16'h6000, 8'hFF);
  endtask

  task automatic test_count_extremes();
    wait_idle();
    write_bank_count(7'd1);
    issue_access(OP_READ, 16'h7FFF, 8'h00);    // folds onto the lower half, bank 15 beyond count
    wait_idle();
    write_bank_count(7'd64);
    issue_access(OP_READ, 16'h0000, 8'h00);
    issue_access(OP_READ, 16'h4000, 8'h00);
    wait_idle();
    write_bank_count(7'd0);
    issue_access(OP_READ, 16'h2000, 8'h00);
    wait_idle();
    write_bank_count(7'd127);
    issue_access(OP_READ, 16'h2000, 8'h00);
  endtask

  task automatic test_random_traffic(logic [CountW-1:0] count, int n_items);
    int sent;
    int pick;
    int reads;
    sent = 0;
    wait_idle();
    write_bank_count(count);
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 1)) begin
          issue_access(OP_WRITE, 16'($urandom_range(0, 16'h7FFF)),
                       {4'($urandom_range(1, 15)), 4'($urandom)});
          sent++;
        end
        load_register(sbm_sel_e'($urandom_range(0, 3)), 5'($urandom));
        sent += RegW;
      end else if (pick < 80) begin
        reads = $urandom_range(1, 4);
        repeat (reads) begin
          issue_access(OP_READ, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
          sent++;
        end
      end else if (pick < 88) begin
        issue_access(OP_WRITE, 16'($urandom_range(0, 16'h7FFF)),
                     {4'($urandom_range(1, 15)), 4'($urandom)});
        sent++;
      end else begin
        issue_access(op_e'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_reads();
    test_serial_loads();
    test_count_extremes();

    test_random_traffic(7'd2, 140);
    test_random_traffic(7'd16, 140);
    test_random_traffic(7'd1, 140);
    test_random_traffic(7'd64, 160);
    test_random_traffic(7'd5, 140);
    test_random_traffic(7'd0, 100);
    test_random_traffic(7'd127, 100);
    test_random_traffic(7'($urandom_range(1, 64)), 140);
    test_random_traffic(7'd3, 140);
    test_random_traffic(7'd65, 100);
    test_random_traffic(7'd40, 140);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
